// ===== rtl/core/amgs_pkg.sv =====
// ----------------------------------------------------------------------------
// amgs_pkg
// Shared types and constants for the adjacency matrix graph store.
// ----------------------------------------------------------------------------
package amgs_pkg;

  localparam int MAX_NODES_DEF  = 16;
  localparam int FIELD_LIMIT    = 16;  // node fields are 4 bits wide
  localparam int OP_W           = 3;
  localparam int NODE_W         = 4;
  localparam int CNT_W          = 5;
  localparam int NODE_COUNT_RST = 16;

  typedef logic [OP_W-1:0] opcode_t;

  localparam opcode_t OP_ADD_EDGE = 3'd0;
  localparam opcode_t OP_DEL_EDGE = 3'd1;
  localparam opcode_t OP_MARK     = 3'd2;
  localparam opcode_t OP_QUERY    = 3'd3;
  localparam opcode_t OP_LIST     = 3'd4;
  localparam opcode_t OP_CLEAR    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_A,
    ST_EDGE_B,
    ST_LIST_LOAD,
    ST_LIST,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/core/adjacency_matrix_graph_store.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store
// Undirected graph as a bit matrix of edges in a synchronous RAM, plus a
// visited bitmap. Edge add/remove, mark/query visited, neighbour listing, clear.
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, in_opcode, in_node_a/b     | request
//  out     | out_valid, out_stall, out_status ... out_last  | result
//  cfg     | cfg_wr_en, cfg_wr_data (node_count)            | write only
//
//  Mark, query, clear, error and undefined opcodes go straight to a response.
//  Edge add/remove: read-modify-write of row a, then row b (one write port).
//  List: one result a cycle per unvisited neighbour, or one if none, unless stalled.
//  Reset and clear drop per-row valid bits at once; no clearing pass.
//  A stalled output holds its result; the FSM waits for the slot to free.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store
  import amgs_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,

  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_status,
  output logic              out_visited_flag,
  output logic              out_found,
  output logic [NODE_W-1:0] out_neighbour,
  output logic [CNT_W-1:0]  out_neighbour_total,
  output logic              out_last
);

  // only the first 16 nodes are addressable through the node fields
  localparam int NODES = (MAX_NODES < FIELD_LIMIT) ? MAX_NODES : FIELD_LIMIT;
  localparam int IDX_W = $clog2(NODES);
  localparam logic [CNT_W-1:0] NODES_V = CNT_W'(NODES);

  typedef logic [NODES-1:0] row_t;
  typedef logic [IDX_W-1:0] idx_t;

  // edge matrix RAM
  row_t adj_mem [NODES];
  row_t mem_rdata_r;
  logic mem_rd_ok_r;
  row_t row_valid_r, row_valid_nxt;
  logic mem_we;
  idx_t mem_waddr, mem_raddr;
  row_t mem_wdata;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  node_count_r;
  row_t              visited_r, visited_nxt;
  idx_t              a_idx_r, a_idx_nxt, b_idx_r, b_idx_nxt;
  logic              del_r, del_nxt;
  logic              res_status_r, res_status_nxt;
  logic              res_vis_r, res_vis_nxt;
  row_t              cand_r, cand_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic              out_visited_flag_r, out_visited_flag_nxt;
  logic              out_found_r, out_found_nxt;
  logic [NODE_W-1:0] out_neighbour_r, out_neighbour_nxt;
  logic [CNT_W-1:0]  out_neighbour_total_r, out_neighbour_total_nxt;
  logic              out_last_r, out_last_nxt;

  logic [CNT_W-1:0] lim;
  row_t             lim_mask;
  row_t             row_use;
  row_t             bit_a, bit_b;
  logic             accept;
  logic             slot_free;
  logic             range_err;
  idx_t             low_idx;
  row_t             low_bit;
  row_t             cand_rest;

  assign lim = (node_count_r < NODES_V) ? node_count_r : NODES_V;

  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      lim_mask[i] = (CNT_W'(i) < lim);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  assign range_err =
      ((in_opcode <= OP_LIST) && ({1'b0, in_node_a} >= lim)) ||
      ((in_opcode inside {OP_ADD_EDGE, OP_DEL_EDGE}) && ({1'b0, in_node_b} >= lim));

  // rows never written since reset or clear read as zero
  assign row_use = mem_rd_ok_r ? mem_rdata_r : '0;

  always_comb begin
    bit_a = '0;
    bit_b = '0;
    bit_a[a_idx_r] = 1'b1;
    bit_b[b_idx_r] = 1'b1;
  end

  // lowest pending neighbour
  always_comb begin
    low_idx = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (cand_r[i]) begin
        low_idx = IDX_W'(i);
      end
    end
    low_bit = '0;
    low_bit[low_idx] = 1'b1;
  end

  assign cand_rest = cand_r & ~low_bit;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (range_err) begin
            state_nxt = ST_RESP;
          end else if (in_opcode inside {OP_ADD_EDGE, OP_DEL_EDGE}) begin
            state_nxt = ST_EDGE_A;
          end else if (in_opcode == OP_LIST) begin
            state_nxt = ST_LIST_LOAD;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_EDGE_A:    state_nxt = ST_EDGE_B;
      ST_EDGE_B:    state_nxt = ST_RESP;
      ST_LIST_LOAD: state_nxt = ST_LIST;
      ST_LIST: begin
        if (slot_free && ((cand_r == '0) || (cand_rest == '0))) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = a_idx_r;
    mem_wdata      = row_use;
    mem_raddr      = in_node_a[IDX_W-1:0];
    row_valid_nxt  = row_valid_r;
    visited_nxt    = visited_r;
    a_idx_nxt      = a_idx_r;
    b_idx_nxt      = b_idx_r;
    del_nxt        = del_r;
    res_status_nxt = res_status_r;
    res_vis_nxt    = res_vis_r;
    cand_nxt       = cand_r;
    count_nxt      = count_r;

    out_valid_nxt           = out_valid_r && out_stall;
    out_status_nxt          = out_status_r;
    out_visited_flag_nxt    = out_visited_flag_r;
    out_found_nxt           = out_found_r;
    out_neighbour_nxt       = out_neighbour_r;
    out_neighbour_total_nxt = out_neighbour_total_r;
    out_last_nxt            = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          a_idx_nxt      = in_node_a[IDX_W-1:0];
          b_idx_nxt      = in_node_b[IDX_W-1:0];
          del_nxt        = (in_opcode == OP_DEL_EDGE);
          res_status_nxt = range_err;
          res_vis_nxt    = 1'b0;
          if (!range_err) begin
            case (in_opcode)
              OP_MARK:  visited_nxt[in_node_a[IDX_W-1:0]] = 1'b1;
              OP_QUERY: res_vis_nxt = visited_r[in_node_a[IDX_W-1:0]];
              OP_CLEAR: begin
                visited_nxt   = '0;
                row_valid_nxt = '0;
              end
              default: ;
            endcase
          end
        end
      end
      ST_EDGE_A: begin
        mem_we    = 1'b1;
        mem_waddr = a_idx_r;
        mem_wdata = del_r ? (row_use & ~bit_b) : (row_use | bit_b);
        row_valid_nxt[a_idx_r] = 1'b1;
        mem_raddr = b_idx_r;
      end
      ST_EDGE_B: begin
        // a self loop rereads row a; only bit a differs and it is rewritten
        mem_we    = 1'b1;
        mem_waddr = b_idx_r;
        mem_wdata = del_r ? (row_use & ~bit_a) : (row_use | bit_a);
        row_valid_nxt[b_idx_r] = 1'b1;
      end
      ST_LIST_LOAD: begin
        cand_nxt  = row_use & ~visited_r & lim_mask;
        count_nxt = '0;
      end
      ST_LIST: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_status_nxt       = 1'b0;
          out_visited_flag_nxt = 1'b0;
          if (cand_r == '0) begin
            out_found_nxt           = 1'b0;
            out_neighbour_nxt       = '0;
            out_neighbour_total_nxt = '0;
            out_last_nxt            = 1'b1;
          end else begin
            out_found_nxt           = 1'b1;
            out_neighbour_nxt       = NODE_W'(low_idx);
            out_neighbour_total_nxt = count_r + CNT_W'(1);
            out_last_nxt            = (cand_rest == '0);
            cand_nxt                = cand_rest;
            count_nxt               = count_r + CNT_W'(1);
          end
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_status_nxt          = res_status_r;
          out_visited_flag_nxt    = res_vis_r;
          out_found_nxt           = 1'b0;
          out_neighbour_nxt       = '0;
          out_neighbour_total_nxt = '0;
          out_last_nxt            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // edge RAM: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      adj_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= adj_mem[mem_raddr];
    mem_rd_ok_r <= row_valid_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= CNT_W'(NODE_COUNT_RST);
      row_valid_r  <= '0;
      visited_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_valid_r <= row_valid_nxt;
      visited_r   <= visited_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_idx_r               <= a_idx_nxt;
    b_idx_r               <= b_idx_nxt;
    del_r                 <= del_nxt;
    res_status_r          <= res_status_nxt;
    res_vis_r             <= res_vis_nxt;
    cand_r                <= cand_nxt;
    count_r               <= count_nxt;
    out_status_r          <= out_status_nxt;
    out_visited_flag_r    <= out_visited_flag_nxt;
    out_found_r           <= out_found_nxt;
    out_neighbour_r       <= out_neighbour_nxt;
    out_neighbour_total_r <= out_neighbour_total_nxt;
    out_last_r            <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_visited_flag    = out_visited_flag_r;
  assign out_found           = out_found_r;
  assign out_neighbour       = out_neighbour_r;
  assign out_neighbour_total = out_neighbour_total_r;
  assign out_last            = out_last_r;

endmodule
